>>> hw/rtl/lscc_pkg.sv
// Shared types and constants of the level-set cell classifier.
// Used by every module of the block; depends on nothing.
`default_nettype none

package lscc_pkg;

	localparam int MAX_FUNCTIONS = 16;
	localparam int SAMPLE_BITS   = 32;
	localparam int NUM_SAMPLES   = 9;
	localparam int NUM_EDGES     = 4;
	localparam int EPS_BITS      = 31;
	localparam int COLOR_BITS    = 8;
	localparam int FIDX_BITS     = 4;
	localparam int KCNT_BITS     = 5;

	localparam int CW   = SAMPLE_BITS + 4;
	localparam int MW   = SAMPLE_BITS + 3;
	localparam int LO_W = (MW + 1) / 2;
	localparam int HI_W = MW - LO_W;
	localparam int PW   = 2 * MW + 2;
	localparam int GW   = (MW > EPS_BITS) ? MW : EPS_BITS;

	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	localparam int IN_FIELD_BITS = NUM_SAMPLES * SAMPLE_BITS + 1 + COLOR_BITS;
	localparam int IN_BITS       = ((IN_FIELD_BITS + 7) / 8) * 8;
	localparam int OUT_BITS      = 24;

	localparam int unsigned EDGE_NODE [NUM_EDGES][3] = '{
		'{0, 3, 6}, '{2, 5, 8}, '{0, 1, 2}, '{6, 7, 8}
	};

	typedef enum logic [1:0] {
		LOC_INSIDE    = 2'd0,
		LOC_OUTSIDE   = 2'd1,
		LOC_INTERFACE = 2'd2
	} loc_t;

	typedef enum logic [1:0] {
		CLS_NEG   = 2'd0,
		CLS_POS   = 2'd1,
		CLS_CROSS = 2'd2
	} cls_t;

	typedef enum logic {
		ACT_INTERSECT = 1'b0,
		ACT_ADD       = 1'b1
	} act_t;

	typedef struct packed {
		cls_t                  cls;
		act_t                  action;
		logic [COLOR_BITS-1:0] color;
		logic                  last;
	} q_item_t;

	typedef struct packed {
		logic    push;
		q_item_t item;
	} q_wr_t;

	typedef struct packed {
		logic [QAW:0] count;
		q_item_t      head;
	} q_rd_t;

endpackage

`default_nettype wire

>>> hw/rtl/lscc_front.sv
// Front part: accepts input beats, classifies each function by sign and edge test.
// Two-stage pipeline feeding the queue; uses lscc_pkg.
`default_nettype none

module lscc_front import lscc_pkg::*; (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  wire  [IN_BITS-1:0]     s_tdata,
	input  wire                    s_tlast,
	input  wire  [EPS_BITS-1:0]    curvature_eps,
	input  wire  [QAW:0]           q_count,
	output q_wr_t                  q_wr
);

	logic signed [SAMPLE_BITS-1:0] smp [NUM_SAMPLES];
	logic signed [CW-1:0] c0_w [NUM_EDGES];
	logic signed [CW-1:0] c1_w [NUM_EDGES];
	logic signed [CW-1:0] c2_w [NUM_EDGES];
	logic [MW-1:0] m0_w [NUM_EDGES];
	logic [MW-1:0] m1_w [NUM_EDGES];
	logic [MW-1:0] m2_w [NUM_EDGES];
	logic          pre_w [NUM_EDGES];
	logic          neg_w, pos_w, accept;
	logic [QAW+1:0] occ;

	logic                  v_s1;
	logic                  pre_s1 [NUM_EDGES];
	logic [MW-1:0]         m0_s1 [NUM_EDGES];
	logic [MW-1:0]         m1_s1 [NUM_EDGES];
	logic [MW-1:0]         m2_s1 [NUM_EDGES];
	logic                  neg_s1, pos_s1, last_s1;
	act_t                  act_s1;
	logic [COLOR_BITS-1:0] color_s1;

	logic                  v_s2;
	logic                  pre_s2 [NUM_EDGES];
	logic [2*HI_W-1:0]     ahh_s2 [NUM_EDGES];
	logic [MW-1:0]         ahl_s2 [NUM_EDGES];
	logic [MW-1:0]         alh_s2 [NUM_EDGES];
	logic [2*LO_W-1:0]     all_s2 [NUM_EDGES];
	logic [2*HI_W-1:0]     bhh_s2 [NUM_EDGES];
	logic [MW-1:0]         bhl_s2 [NUM_EDGES];
	logic [2*LO_W-1:0]     bll_s2 [NUM_EDGES];
	logic                  neg_s2, pos_s2, last_s2;
	act_t                  act_s2;
	logic [COLOR_BITS-1:0] color_s2;

	logic [PW-1:0] pa_w [NUM_EDGES];
	logic [PW-1:0] pb_w [NUM_EDGES];
	logic          flip_w;

	assign occ = (QAW+2)'(q_count) + (QAW+2)'(v_s1) + (QAW+2)'(v_s2);
	assign s_tready = (occ < (QAW+2)'(QDEPTH));
	assign accept = s_tvalid && s_tready;

	always_comb begin
		neg_w = 1'b1;
		pos_w = 1'b1;
		for (int k = 0; k < NUM_SAMPLES; k++) begin
			smp[k] = s_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
			neg_w = neg_w && (smp[k] < 0);
			pos_w = pos_w && (smp[k] > 0);
		end
	end

	always_comb begin
		for (int e = 0; e < NUM_EDGES; e++) begin
			logic signed [CW-1:0] p0, p1, p2;
			logic signed [CW:0]   num, den;
			logic                 gate, inner, same;
			p0 = CW'(smp[EDGE_NODE[e][0]]);
			p1 = CW'(smp[EDGE_NODE[e][1]]);
			p2 = CW'(smp[EDGE_NODE[e][2]]);
			c0_w[e] = p0;
			c1_w[e] = (p1 <<< 2) - (p0 <<< 1) - p0 - p2;
			c2_w[e] = (p0 <<< 1) - (p1 <<< 2) + (p2 <<< 1);
			m0_w[e] = MW'(c0_w[e][CW-1] ? -c0_w[e] : c0_w[e]);
			m1_w[e] = MW'(c1_w[e][CW-1] ? -c1_w[e] : c1_w[e]);
			m2_w[e] = MW'(c2_w[e][CW-1] ? -c2_w[e] : c2_w[e]);
			num = -((CW+1)'(c1_w[e]));
			den = (CW+1)'(c2_w[e]) <<< 1;
			gate = (GW'(m2_w[e]) > GW'(curvature_eps));
			if (den > 0) begin
				inner = (num > 0) && (num < den);
			end else begin
				inner = (num < 0) && (num > den);
			end
			same = (c0_w[e] != 0) && (c2_w[e] != 0) && (c0_w[e][CW-1] == c2_w[e][CW-1]);
			pre_w[e] = gate && inner && same;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int e = 0; e < NUM_EDGES; e++) begin
			pre_s1[e] <= pre_w[e];
			m0_s1[e]  <= m0_w[e];
			m1_s1[e]  <= m1_w[e];
			m2_s1[e]  <= m2_w[e];
		end
		neg_s1   <= neg_w;
		pos_s1   <= pos_w;
		act_s1   <= act_t'(s_tdata[NUM_SAMPLES*SAMPLE_BITS]);
		color_s1 <= s_tdata[NUM_SAMPLES*SAMPLE_BITS+1 +: COLOR_BITS];
		last_s1  <= s_tlast;
	end

	always_ff @(posedge clk) begin
		for (int e = 0; e < NUM_EDGES; e++) begin
			pre_s2[e] <= pre_s1[e];
			ahh_s2[e] <= m0_s1[e][MW-1:LO_W] * m2_s1[e][MW-1:LO_W];
			ahl_s2[e] <= m0_s1[e][MW-1:LO_W] * m2_s1[e][LO_W-1:0];
			alh_s2[e] <= m0_s1[e][LO_W-1:0] * m2_s1[e][MW-1:LO_W];
			all_s2[e] <= m0_s1[e][LO_W-1:0] * m2_s1[e][LO_W-1:0];
			bhh_s2[e] <= m1_s1[e][MW-1:LO_W] * m1_s1[e][MW-1:LO_W];
			bhl_s2[e] <= m1_s1[e][MW-1:LO_W] * m1_s1[e][LO_W-1:0];
			bll_s2[e] <= m1_s1[e][LO_W-1:0] * m1_s1[e][LO_W-1:0];
		end
		neg_s2   <= neg_s1;
		pos_s2   <= pos_s1;
		act_s2   <= act_s1;
		color_s2 <= color_s1;
		last_s2  <= last_s1;
	end

	always_comb begin
		flip_w = 1'b0;
		for (int e = 0; e < NUM_EDGES; e++) begin
			pa_w[e] = ((PW'(ahh_s2[e]) << (2*LO_W)) + (PW'(ahl_s2[e]) << LO_W)
				+ (PW'(alh_s2[e]) << LO_W) + PW'(all_s2[e])) << 2;
			pb_w[e] = (PW'(bhh_s2[e]) << (2*LO_W)) + (PW'(bhl_s2[e]) << (LO_W+1))
				+ PW'(bll_s2[e]);
			flip_w = flip_w || (pre_s2[e] && (pa_w[e] < pb_w[e]));
		end
	end

	always_comb begin
		q_wr.push        = v_s2;
		q_wr.item.action = act_s2;
		q_wr.item.color  = color_s2;
		q_wr.item.last   = last_s2;
		if (!(neg_s2 || pos_s2) || flip_w) begin
			q_wr.item.cls = CLS_CROSS;
		end else if (pos_s2) begin
			q_wr.item.cls = CLS_POS;
		end else begin
			q_wr.item.cls = CLS_NEG;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/lscc_queue.sv
// Short queue between the classifying front and the state-update back.
// Register array with read and write pointers; uses lscc_pkg.
`default_nettype none

module lscc_queue import lscc_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  q_wr_t q_wr,
	input  wire   pop,
	output q_rd_t q_rd
);

	q_item_t        mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q, rptr_q;
	logic [QAW:0]   count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (q_wr.push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			count_q <= count_q + (QAW+1)'(q_wr.push) - (QAW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (q_wr.push) begin
			mem_q[wptr_q] <= q_wr.item;
		end
	end

	assign q_rd.count = count_q;
	assign q_rd.head  = mem_q[rptr_q];

endmodule

`default_nettype wire

>>> hw/rtl/lscc_back.sv
// Back part: applies classified functions to the cell state and drives result beats.
// Holds location and counters plus the output register; uses lscc_pkg.
`default_nettype none

module lscc_back import lscc_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  q_rd_t               q_rd,
	output logic                pop,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [OUT_BITS-1:0] m_tdata,
	output logic                m_tlast
);

	loc_t                  loc_q, loc_n;
	logic [FIDX_BITS-1:0]  fcnt_q;
	logic [KCNT_BITS-1:0]  kcnt_q, kcnt_n;
	logic                  kept_n, clr_n;
	act_t                  kact_n;
	logic [COLOR_BITS-1:0] kclr_n;

	logic                  ov_q;
	loc_t                  o_loc_q;
	cls_t                  o_cls_q;
	logic                  o_kept_q, o_clr_q, o_last_q;
	act_t                  o_kact_q;
	logic [COLOR_BITS-1:0] o_kclr_q;
	logic [FIDX_BITS-1:0]  o_fidx_q;
	logic [KCNT_BITS-1:0]  o_kcnt_q;

	q_item_t it;
	assign it  = q_rd.head;
	assign pop = (q_rd.count != '0) && (!ov_q || m_tready);

	always_comb begin
		loc_n  = loc_q;
		kcnt_n = kcnt_q;
		kept_n = 1'b0;
		clr_n  = 1'b0;
		kact_n = ACT_INTERSECT;
		kclr_n = '0;
		case (it.cls)
			CLS_POS: begin
				if (it.action == ACT_INTERSECT) begin
					loc_n  = LOC_OUTSIDE;
					kcnt_n = '0;
					clr_n  = 1'b1;
				end
			end
			CLS_NEG: begin
				if (it.action == ACT_ADD) begin
					loc_n  = LOC_INSIDE;
					kcnt_n = '0;
					clr_n  = 1'b1;
				end
			end
			default: begin
				if (loc_q == LOC_INTERFACE
					|| (loc_q == LOC_INSIDE && it.action == ACT_INTERSECT)
					|| (loc_q == LOC_OUTSIDE && it.action == ACT_ADD)) begin
					loc_n  = LOC_INTERFACE;
					kept_n = 1'b1;
					kact_n = (kcnt_q == '0) ? ACT_INTERSECT : it.action;
					kclr_n = it.color;
					if (kcnt_q < KCNT_BITS'(MAX_FUNCTIONS)) begin
						kcnt_n = kcnt_q + 1'b1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_q  <= LOC_INSIDE;
			fcnt_q <= '0;
			kcnt_q <= '0;
			ov_q   <= 1'b0;
		end else begin
			if (pop) begin
				ov_q <= 1'b1;
				if (it.last) begin
					loc_q  <= LOC_INSIDE;
					fcnt_q <= '0;
					kcnt_q <= '0;
				end else begin
					loc_q  <= loc_n;
					kcnt_q <= kcnt_n;
					if (fcnt_q < FIDX_BITS'(MAX_FUNCTIONS - 1)) begin
						fcnt_q <= fcnt_q + 1'b1;
					end
				end
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			o_loc_q  <= loc_n;
			o_cls_q  <= it.cls;
			o_kept_q <= kept_n;
			o_clr_q  <= clr_n;
			o_kact_q <= kact_n;
			o_kclr_q <= kclr_n;
			o_fidx_q <= fcnt_q;
			o_kcnt_q <= kcnt_n;
			o_last_q <= it.last;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tlast  = o_last_q;
	assign m_tdata  = {o_kcnt_q, o_fidx_q, o_kclr_q, o_kact_q, o_clr_q, o_kept_q,
		o_cls_q, o_loc_q};

	a_kept_iface: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && o_kept_q) |-> (o_loc_q == LOC_INTERFACE && o_cls_q == CLS_CROSS))
		else $error("kept result outside interface");
	a_clr_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && o_clr_q) |-> (o_kcnt_q == '0 && !o_kept_q))
		else $error("cleared result with kept entries");
	a_cell_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && it.last) |=> (loc_q == LOC_INSIDE && fcnt_q == '0 && kcnt_q == '0))
		else $error("state not reset after last function");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !m_tready) |=> (ov_q && $stable(m_tdata)))
		else $error("result changed under stall");

endmodule

`default_nettype wire

>>> hw/rtl/level_set_cell_classifier.sv
// Top level of the level-set cell classifier: front, queue, back, config register.
// Depends on lscc_pkg, lscc_front, lscc_queue and lscc_back.
//
// Usage:
//   s_* carries one level-set function per beat: nine samples, action and color
//   in s_tdata, the cell's last function on s_tlast. m_* returns one result beat
//   per input beat, in order, with cell_done on m_tlast.
//   cfg_we/cfg_data write curvature_eps (reset 1); write only while idle.
// Datapath from input beat to result beat: two front pipeline stages with the edge
//   multipliers, then the queue, then the output register.
// Throughput is one beat per cycle while m_tready stays high, set by the four-entry
//   queue credit check in the front.
// Reset: arst_n clears the pipeline, the queue and the cell state; the cell
//   starts inside with empty counters.
// Stall: when m_tready is low the result beat holds; the front keeps taking
//   beats until the queue and pipeline hold four, then drops s_tready.
`default_nettype none

module level_set_cell_classifier import lscc_pkg::*; (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 s_tvalid,
	output logic                s_tready,
	// sample_00, sample_10, sample_20, sample_01, sample_11, sample_21,
	// sample_02, sample_12, sample_22, combine_action, region_color, zero fill
	input  wire  [IN_BITS-1:0]  s_tdata,
	input  wire                 s_tlast,
	output logic                m_tvalid,
	input  wire                 m_tready,
	// location, sign_class, kept, cleared, kept_action, kept_color,
	// function_index, kept_count
	output logic [OUT_BITS-1:0] m_tdata,
	output logic                m_tlast,
	input  wire                 cfg_we,
	input  wire  [EPS_BITS-1:0] cfg_data
);

	logic [EPS_BITS-1:0] eps_q;
	q_wr_t q_wr;
	q_rd_t q_rd;
	logic  pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EPS_BITS'(1);
		end else if (cfg_we) begin
			eps_q <= cfg_data;
		end
	end

	lscc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_tvalid      (s_tvalid),
		.s_tready      (s_tready),
		.s_tdata       (s_tdata),
		.s_tlast       (s_tlast),
		.curvature_eps (eps_q),
		.q_count       (q_rd.count),
		.q_wr          (q_wr)
	);

	lscc_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.q_rd   (q_rd)
	);

	lscc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

>>> tb/tb.sv
// Self-checking testbench for level_set_cell_classifier: a directed table, then random
// cells, with each result beat checked against an in-bench classifier model.
// Depends on lscc_pkg and the level_set_cell_classifier RTL.
`default_nettype none

module tb;
	import lscc_pkg::*;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] smp [NUM_SAMPLES];
		act_t                          action;
		logic [COLOR_BITS-1:0]         color;
		logic                          last;
	} func_t;

	typedef struct packed {
		loc_t                  loc;
		cls_t                  cls;
		logic                  kept;
		logic                  cleared;
		logic                  kact;
		logic [COLOR_BITS-1:0] kcolor;
		logic [FIDX_BITS-1:0]  fidx;
		logic [KCNT_BITS-1:0]  kcnt;
		logic                  done;
	} result_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_BITS-1:0] s_tdata = '0;
	logic s_tlast = 0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_BITS-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 0;
	logic [EPS_BITS-1:0] cfg_data = '0;

	always #1 clk = ~clk;

	level_set_cell_classifier dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	// model state
	logic [EPS_BITS-1:0]  eps_q = 1;
	loc_t                 loc_q = LOC_INSIDE;
	logic [FIDX_BITS-1:0] fidx_q = 0;
	logic [KCNT_BITS-1:0] kcnt_q = 0;

	result_t expected_results [$];
	int errors = 0;
	int stall_hold = 0;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	task automatic exp_put(input result_t r);
		expected_results.insert(expected_results.size(), r);
	endtask

	function automatic int sgn(input longint v);
		return (v > 0) - (v < 0);
	endfunction

	function automatic bit edge_flips(input longint p0, input longint p1, input longint p2);
		longint c0, c1, c2, num, den;
		logic signed [127:0] disc;
		bit inner;
		int sd;
		c0 = p0;
		c1 = -3 * p0 + 4 * p1 - p2;
		c2 = 2 * p0 - 4 * p1 + 2 * p2;
		num = -c1;
		den = 2 * c2;
		if (c2 == 0 || !((c2 < 0 ? -c2 : c2) > longint'(eps_q))) return 0;
		inner = (den > 0) ? (num > 0 && num < den) : (num < 0 && num > den);
		if (!inner) return 0;
		disc = 128'(4) * 128'(c0) * 128'(c2) - 128'(c1) * 128'(c1);
		sd = (disc > 0) - (disc < 0);
		return sd * sgn(c2) * sgn(c0) < 0;
	endfunction

	function automatic result_t classify(input func_t f);
		result_t r;
		bit neg, pos;
		neg = 1;
		pos = 1;
		foreach (f.smp[e]) begin
			neg &= f.smp[e] < 0;
			pos &= f.smp[e] > 0;
		end
		if (neg || pos) begin
			for (int e = 0; e < NUM_EDGES; e++)
				if (edge_flips(f.smp[EDGE_NODE[e][0]], f.smp[EDGE_NODE[e][1]],
						f.smp[EDGE_NODE[e][2]])) begin
					neg = 0;
					pos = 0;
				end
		end
		r = '0;
		if (pos) begin
			r.cls = CLS_POS;
			if (f.action == ACT_INTERSECT) begin
				loc_q = LOC_OUTSIDE;
				kcnt_q = 0;
				r.cleared = 1;
			end
		end else if (neg) begin
			r.cls = CLS_NEG;
			if (f.action == ACT_ADD) begin
				loc_q = LOC_INSIDE;
				kcnt_q = 0;
				r.cleared = 1;
			end
		end else begin
			r.cls = CLS_CROSS;
			if (loc_q == LOC_INTERFACE || (loc_q == LOC_INSIDE && f.action == ACT_INTERSECT)
					|| (loc_q == LOC_OUTSIDE && f.action == ACT_ADD)) begin
				loc_q = LOC_INTERFACE;
				r.kept = 1;
				r.kact = (kcnt_q == 0) ? ACT_INTERSECT : f.action;
				r.kcolor = f.color;
				if (kcnt_q < MAX_FUNCTIONS) kcnt_q++;
			end
		end
		r.loc = loc_q;
		r.fidx = fidx_q;
		r.kcnt = kcnt_q;
		r.done = f.last;
		if (f.last) begin
			loc_q = LOC_INSIDE;
			fidx_q = 0;
			kcnt_q = 0;
		end else if (fidx_q < MAX_FUNCTIONS - 1) begin
			fidx_q++;
		end
		return r;
	endfunction

	function automatic logic [IN_BITS-1:0] pack_func(input func_t f);
		logic [IN_BITS-1:0] d;
		d = '0;
		for (int k = 0; k < NUM_SAMPLES; k++) d[k*SAMPLE_BITS +: SAMPLE_BITS] = f.smp[k];
		d[NUM_SAMPLES*SAMPLE_BITS] = f.action;
		d[NUM_SAMPLES*SAMPLE_BITS+1 +: COLOR_BITS] = f.color;
		return d;
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] rand_sample(input int sgn_sel);
		logic signed [SAMPLE_BITS-1:0] v;
		case ($urandom_range(0, 3))
			0: v = $urandom;
			1: v = $urandom_range(1, 64);
			2: v = $urandom_range(1, 1 << 20);
			default: v = $urandom_range(1, 32'h7fff_ffff);
		endcase
		if (v < 0) v = -v;
		if (v <= 0) v = 1;
		if (sgn_sel < 0) v = -v;
		else if (sgn_sel == 0 && $urandom_range(0, 1)) v = -v;
		return v;
	endfunction

	function automatic func_t rand_func(input bit last);
		func_t f;
		int mode;
		mode = $urandom_range(0, 9);
		foreach (f.smp[k]) begin
			case (mode)
				0, 1, 2: f.smp[k] = rand_sample(1);
				3, 4, 5: f.smp[k] = rand_sample(-1);
				6: f.smp[k] = $urandom;
				default: f.smp[k] = rand_sample(0);
			endcase
		end
		// bend one edge: equal ends, and a midpoint of the same sign that is flipped across zero at random
		if (mode < 6 && $urandom_range(0, 1)) begin
			int e;
			e = $urandom_range(0, NUM_EDGES - 1);
			f.smp[EDGE_NODE[e][0]] = (mode < 3) ? $urandom_range(1, 4000) : -$urandom_range(1, 4000);
			f.smp[EDGE_NODE[e][2]] = f.smp[EDGE_NODE[e][0]];
			f.smp[EDGE_NODE[e][1]] = (mode < 3) ? $urandom_range(1, 2000) : -$urandom_range(1, 2000);
			if ($urandom_range(0, 1)) f.smp[EDGE_NODE[e][1]] = -f.smp[EDGE_NODE[e][1]];
		end
		if (mode == 8) f.smp[$urandom_range(0, 8)] = 0;
		f.action = act_t'($urandom_range(0, 1));
		f.color = $urandom;
		f.last = last;
		return f;
	endfunction

	task automatic send_func(input func_t f);
		int gap;
		gap = $urandom_range(0, 14);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= pack_func(f);
		s_tlast <= f.last;
		do @(posedge clk); while (!s_tready);
		exp_put(classify(f));
	endtask

	task automatic wait_idle();
		s_tvalid <= 0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_eps(input logic [EPS_BITS-1:0] v);
		cfg_we <= 1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 0;
		eps_q = v;
	endtask

	task automatic send_cell(input int len);
		for (int k = 0; k < len; k++) send_func(rand_func(k == len - 1));
	endtask

	// receiver
	initial begin
		result_t got, want;
		int gap;
		@(posedge arst_n);
		forever begin
			if (stall_hold > 0) begin
				m_tready <= 0;
				repeat (stall_hold) @(posedge clk);
				stall_hold = 0;
			end
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
			if (gap > 0) begin
				m_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1;
			do @(posedge clk); while (!m_tvalid);
			got.loc = loc_t'(m_tdata[1:0]);
			got.cls = cls_t'(m_tdata[3:2]);
			got.kept = m_tdata[4];
			got.cleared = m_tdata[5];
			got.kact = m_tdata[6];
			got.kcolor = m_tdata[14:7];
			got.fidx = m_tdata[18:15];
			got.kcnt = m_tdata[23:19];
			got.done = m_tlast;
			if (expected_results.size() == 0) begin
				report("unexpected beat", m_tdata, 0);
			end else begin
				want = expected_results.pop_front();
				if (got.loc != want.loc) report("location", got.loc, want.loc);
				if (got.cls != want.cls) report("sign_class", got.cls, want.cls);
				if (got.kept != want.kept) report("kept", got.kept, want.kept);
				if (got.cleared != want.cleared) report("cleared", got.cleared, want.cleared);
				if (got.kact != want.kact) report("kept_action", got.kact, want.kact);
				if (got.kcolor != want.kcolor) report("kept_color", got.kcolor, want.kcolor);
				if (got.fidx != want.fidx) report("function_index", got.fidx, want.fidx);
				if (got.kcnt != want.kcnt) report("kept_count", got.kcnt, want.kcnt);
				if (got.done != want.done) report("cell_done", got.done, want.done);
			end
		end
	end

	// directed rows: samples all set to one value, except an optional zero at one node
	typedef struct {
		logic signed [SAMPLE_BITS-1:0] fill;
		int                            zero_at;
		act_t                          action;
		logic [COLOR_BITS-1:0]         color;
		logic                          last;
		bit                            has_want;
		cls_t                          want_cls;
		loc_t                          want_loc;
	} row_t;

	row_t directed [] = '{
		'{32'sh7fffffff, -1, ACT_ADD,       8'h00, 0, 1, CLS_POS,   LOC_INSIDE},
		'{-32'sh80000000, -1, ACT_INTERSECT, 8'hff, 0, 1, CLS_NEG,  LOC_INSIDE},
		'{32'sd1,        4, ACT_INTERSECT, 8'ha5, 0, 1, CLS_CROSS, LOC_INTERFACE},
		'{32'sd5,        0, ACT_ADD,       8'h5a, 0, 1, CLS_CROSS, LOC_INTERFACE},
		'{32'sd1,       -1, ACT_INTERSECT, 8'h01, 0, 1, CLS_POS,   LOC_OUTSIDE},
		'{-32'sd1,       8, ACT_ADD,       8'h80, 0, 1, CLS_CROSS, LOC_INTERFACE},
		'{-32'sd1,      -1, ACT_ADD,       8'h7f, 1, 1, CLS_NEG,   LOC_INSIDE},
		'{32'sd0,       -1, ACT_ADD,       8'h33, 0, 1, CLS_CROSS, LOC_INSIDE},
		'{32'sd9,       -1, ACT_ADD,       8'h44, 1, 0, CLS_POS,   LOC_INSIDE}
	};

	initial begin
		func_t f;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) begin
			foreach (f.smp[k]) f.smp[k] = directed[i].fill;
			if (directed[i].zero_at >= 0) f.smp[directed[i].zero_at] = 0;
			f.action = directed[i].action;
			f.color = directed[i].color;
			f.last = directed[i].last;
			send_func(f);
			if (directed[i].has_want && (expected_results[$].cls != directed[i].want_cls
					|| expected_results[$].loc != directed[i].want_loc))
				report("directed row", i, directed[i].want_cls);
		end
		// edge bulges: positive corners, a negative interior extremum, then a positive one
		foreach (f.smp[k]) f.smp[k] = 100;
		f.smp[3] = -20;
		f.action = ACT_INTERSECT;
		f.last = 0;
		send_func(f);
		f.smp[3] = 100;
		f.smp[1] = 60;
		send_func(f);
		// a long cell saturating both counters
		for (int k = 0; k < 20; k++) begin
			foreach (f.smp[n]) f.smp[n] = (n == 4) ? 0 : 32'sd7;
			f.action = act_t'(k % 2);
			f.color = 8'(k);
			f.last = (k == 19);
			send_func(f);
		end
		wait_idle();
		write_eps('1);
		send_cell(6);
		wait_idle();
		write_eps(0);
		send_cell(8);
		// long receiver hold-off while the sender keeps offering
		stall_hold = 300;
		send_cell(10);
		for (int ph = 0; ph < 4; ph++) begin
			wait_idle();
			write_eps(ph == 0 ? 31'd1 : (ph == 1 ? 31'd200 : 31'($urandom)));
			for (int c = 0; c < 22; c++)
				send_cell($urandom_range(0, 7) == 0 ? $urandom_range(14, 18) : $urandom_range(1, 5));
		end
		wait_idle();
		if (errors == 0) begin
			$display("** level_set_cell_classifier: PASSED **");
		end else begin
			$display("** level_set_cell_classifier: FAILED **");
		end
		$finish;
	end

	initial begin
		#400000;
		$display("** level_set_cell_classifier: FAILED **");
		$finish;
	end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/lscc_pkg.sv
hw/rtl/lscc_front.sv
hw/rtl/lscc_queue.sv
hw/rtl/lscc_back.sv
hw/rtl/level_set_cell_classifier.sv
tb/tb.sv
